FILE: rtl/jsu_pkg.sv
// shared types and constants of the json string unescaper
package jsu_pkg;

	localparam logic [1:0] KIND_CP   = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_CTRL    = 3'd0;
	localparam logic [2:0] ERR_ESCAPE  = 3'd1;
	localparam logic [2:0] ERR_UNICODE = 3'd2;
	localparam logic [2:0] ERR_UNTERM  = 3'd3;
	localparam logic [2:0] ERR_UTF8    = 3'd4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam logic [20:0] CP_MAX      = 21'h10FFFF;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	typedef enum logic [3:0] {
		MODE_PLAIN    = 4'd0,
		MODE_ESC      = 4'd1,
		MODE_HEX1     = 4'd2,
		MODE_HEX2     = 4'd3,
		MODE_HEX3     = 4'd4,
		MODE_HEX4     = 4'd5,
		MODE_HELD     = 4'd6,
		MODE_HELD_ESC = 4'd7,
		MODE_LOW1     = 4'd8,
		MODE_LOW2     = 4'd9,
		MODE_LOW3     = 4'd10,
		MODE_LOW4     = 4'd11
	} mode_t;

	typedef struct packed {
		mode_t       parse_mode;
		logic [15:0] hex_value;
		logic [15:0] held_high;
		logic [15:0] low_value;
		logic [20:0] utf8_value;
		logic [1:0]  utf8_left;
		logic [7:0]  utf8_lead;
	} state_t;

	localparam state_t STATE_RESET = '{
		parse_mode: MODE_PLAIN,
		hex_value:  16'h0,
		held_high:  16'h0,
		low_value:  16'h0,
		utf8_value: 21'h0,
		utf8_left:  2'd0,
		utf8_lead:  8'h0
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [20:0] code_point;
		logic [2:0]  error_code;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

FILE: rtl/jsu_decode.sv
// next-state and result logic for one string byte or end marker
module jsu_decode (
	input  jsu_pkg::state_t st,
	input  logic [7:0]      data_byte,
	input  logic            end_marker,
	output jsu_pkg::state_t nx,
	output jsu_pkg::push_t  res
);

	logic        rel;
	logic        m_v;
	logic [1:0]  m_kind;
	logic [20:0] m_cp;
	logic [2:0]  m_err;
	logic        fail;
	logic        clr;
	logic        pb;
	logic        eb;
	logic        finish;
	logic [15:0] fin_val;
	logic [7:0]  lc;
	logic        dig_ok;
	logic [3:0]  dig;
	logic [15:0] hex_next;
	logic [15:0] low_next;
	logic [7:0]  lo;
	logic [7:0]  hi;
	jsu_pkg::result_t held_r;
	jsu_pkg::result_t main_r;

	always_comb begin
		lc = data_byte | jsu_pkg::CH_SPACE;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			dig_ok = 1'b1;
			dig = data_byte[3:0];
		end else if (lc >= 8'h61 && lc <= 8'h66) begin
			dig_ok = 1'b1;
			dig = 4'(lc[3:0] + 4'd9);
		end else begin
			dig_ok = 1'b0;
			dig = 4'd0;
		end
		hex_next = {st.hex_value[11:0], dig};
		low_next = {st.low_value[11:0], dig};
	end

	always_comb begin
		nx = st;
		rel = 1'b0;
		m_v = 1'b0;
		m_kind = jsu_pkg::KIND_CP;
		m_cp = 21'h0;
		m_err = jsu_pkg::ERR_CTRL;
		fail = 1'b0;
		clr = 1'b0;
		pb = 1'b0;
		eb = 1'b0;
		finish = 1'b0;
		fin_val = 16'h0;
		lo = 8'h80;
		hi = 8'hBF;

		if (end_marker) begin
			fail = 1'b1;
			case (st.parse_mode)
				jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2,
				jsu_pkg::MODE_HEX3, jsu_pkg::MODE_HEX4: begin
					m_err = jsu_pkg::ERR_UNICODE;
				end
				jsu_pkg::MODE_HELD, jsu_pkg::MODE_HELD_ESC: begin
					rel = 1'b1;
					m_err = jsu_pkg::ERR_UNTERM;
				end
				jsu_pkg::MODE_LOW1, jsu_pkg::MODE_LOW2,
				jsu_pkg::MODE_LOW3, jsu_pkg::MODE_LOW4: begin
					rel = 1'b1;
					m_err = jsu_pkg::ERR_UNICODE;
				end
				default: begin
					m_err = jsu_pkg::ERR_UNTERM;
				end
			endcase
		end else begin
			case (st.parse_mode)
				jsu_pkg::MODE_PLAIN: begin
					pb = 1'b1;
				end
				jsu_pkg::MODE_ESC: begin
					eb = 1'b1;
				end
				jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3: begin
					if (!dig_ok) begin
						fail = 1'b1;
						m_err = jsu_pkg::ERR_UNICODE;
					end else begin
						nx.hex_value = hex_next;
						nx.parse_mode = jsu_pkg::mode_t'(st.parse_mode + 4'd1);
					end
				end
				jsu_pkg::MODE_HEX4: begin
					if (!dig_ok) begin
						fail = 1'b1;
						m_err = jsu_pkg::ERR_UNICODE;
					end else begin
						nx.hex_value = hex_next;
						finish = 1'b1;
						fin_val = hex_next;
					end
				end
				jsu_pkg::MODE_HELD: begin
					if (data_byte == jsu_pkg::CH_BSL) begin
						nx.parse_mode = jsu_pkg::MODE_HELD_ESC;
					end else begin
						rel = 1'b1;
						pb = 1'b1;
					end
				end
				jsu_pkg::MODE_HELD_ESC: begin
					if (data_byte == jsu_pkg::CH_U) begin
						nx.parse_mode = jsu_pkg::MODE_LOW1;
						nx.low_value = 16'h0;
					end else begin
						rel = 1'b1;
						eb = 1'b1;
					end
				end
				jsu_pkg::MODE_LOW1, jsu_pkg::MODE_LOW2, jsu_pkg::MODE_LOW3: begin
					if (!dig_ok) begin
						rel = 1'b1;
						fail = 1'b1;
						m_err = jsu_pkg::ERR_UNICODE;
					end else begin
						nx.low_value = low_next;
						nx.parse_mode = jsu_pkg::mode_t'(st.parse_mode + 4'd1);
					end
				end
				jsu_pkg::MODE_LOW4: begin
					if (!dig_ok) begin
						rel = 1'b1;
						fail = 1'b1;
						m_err = jsu_pkg::ERR_UNICODE;
					end else begin
						nx.low_value = low_next;
						if (low_next >= jsu_pkg::SURR_LO_MIN && low_next <= jsu_pkg::SURR_LO_MAX) begin
							m_v = 1'b1;
							m_cp = jsu_pkg::SUPP_BASE
								+ 21'({st.held_high[9:0], low_next[9:0]});
							nx.held_high = 16'h0;
							nx.parse_mode = jsu_pkg::MODE_PLAIN;
						end else begin
							rel = 1'b1;
							finish = 1'b1;
							fin_val = low_next;
						end
					end
				end
				default: begin
					nx = jsu_pkg::STATE_RESET;
					pb = 1'b1;
				end
			endcase
		end

		if (rel) begin
			nx.held_high = 16'h0;
			nx.parse_mode = jsu_pkg::MODE_PLAIN;
		end

		if (pb) begin
			if (nx.utf8_left != 2'd0) begin
				case (nx.utf8_lead)
					8'hE0: lo = 8'hA0;
					8'hED: hi = 8'h9F;
					8'hF0: lo = 8'h90;
					8'hF4: hi = 8'h8F;
					default: begin
						lo = 8'h80;
						hi = 8'hBF;
					end
				endcase
				if (data_byte < jsu_pkg::CH_SPACE) begin
					fail = 1'b1;
					m_err = jsu_pkg::ERR_CTRL;
				end else if (data_byte < lo || data_byte > hi) begin
					fail = 1'b1;
					m_err = jsu_pkg::ERR_UTF8;
				end else begin
					nx.utf8_value = {nx.utf8_value[14:0], data_byte[5:0]};
					nx.utf8_lead = 8'h0;
					nx.utf8_left = nx.utf8_left - 2'd1;
					if (nx.utf8_left == 2'd0) begin
						m_v = 1'b1;
						m_cp = nx.utf8_value;
						nx.utf8_value = 21'h0;
					end
				end
			end else if (data_byte == jsu_pkg::CH_QUOTE) begin
				m_v = 1'b1;
				m_kind = jsu_pkg::KIND_DONE;
				clr = 1'b1;
			end else if (data_byte == jsu_pkg::CH_BSL) begin
				nx.parse_mode = jsu_pkg::MODE_ESC;
			end else if (data_byte < jsu_pkg::CH_SPACE) begin
				fail = 1'b1;
				m_err = jsu_pkg::ERR_CTRL;
			end else if (data_byte < 8'h80) begin
				m_v = 1'b1;
				m_cp = 21'(data_byte);
			end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
				nx.utf8_left = 2'd1;
				nx.utf8_value = 21'(data_byte[4:0]);
				nx.utf8_lead = data_byte;
			end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
				nx.utf8_left = 2'd2;
				nx.utf8_value = 21'(data_byte[3:0]);
				nx.utf8_lead = data_byte;
			end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
				nx.utf8_left = 2'd3;
				nx.utf8_value = 21'(data_byte[2:0]);
				nx.utf8_lead = data_byte;
			end else begin
				fail = 1'b1;
				m_err = jsu_pkg::ERR_UTF8;
			end
		end

		if (eb) begin
			m_v = 1'b1;
			nx.parse_mode = jsu_pkg::MODE_PLAIN;
			case (data_byte)
				jsu_pkg::CH_QUOTE: m_cp = 21'h22;
				jsu_pkg::CH_BSL:   m_cp = 21'h5C;
				jsu_pkg::CH_SLASH: m_cp = 21'h2F;
				jsu_pkg::CH_B:     m_cp = 21'h08;
				jsu_pkg::CH_F:     m_cp = 21'h0C;
				jsu_pkg::CH_N:     m_cp = 21'h0A;
				jsu_pkg::CH_R:     m_cp = 21'h0D;
				jsu_pkg::CH_T:     m_cp = 21'h09;
				jsu_pkg::CH_U: begin
					m_v = 1'b0;
					nx.parse_mode = jsu_pkg::MODE_HEX1;
					nx.hex_value = 16'h0;
				end
				default: begin
					m_v = 1'b0;
					fail = 1'b1;
					m_err = jsu_pkg::ERR_ESCAPE;
				end
			endcase
		end

		if (finish) begin
			if (fin_val >= jsu_pkg::SURR_HI_MIN && fin_val <= jsu_pkg::SURR_HI_MAX) begin
				nx.held_high = fin_val;
				nx.parse_mode = jsu_pkg::MODE_HELD;
			end else begin
				m_v = 1'b1;
				m_cp = 21'(fin_val);
				nx.parse_mode = jsu_pkg::MODE_PLAIN;
			end
		end

		if (fail) begin
			m_v = 1'b1;
			m_kind = jsu_pkg::KIND_ERR;
			m_cp = 21'h0;
			clr = 1'b1;
		end else begin
			m_err = jsu_pkg::ERR_CTRL;
		end

		if (clr) begin
			nx = jsu_pkg::STATE_RESET;
		end
	end

	always_comb begin
		held_r.kind = jsu_pkg::KIND_CP;
		held_r.code_point = 21'(st.held_high);
		held_r.error_code = jsu_pkg::ERR_CTRL;
		held_r.last = !m_v;
		main_r.kind = m_kind;
		main_r.code_point = m_cp;
		main_r.error_code = m_err;
		main_r.last = 1'b1;
		res.count = 2'({1'b0, rel} + {1'b0, m_v});
		res.r0 = rel ? held_r : main_r;
		res.r1 = main_r;
	end

endmodule

FILE: rtl/jsu_outq.sv
// result queue that takes up to two results per cycle and hands out one
module jsu_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_pkg::push_t   push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output jsu_pkg::result_t out_res
);

	localparam int CW = jsu_pkg::OQ_AW + 1;

	jsu_pkg::result_t          mem_q [jsu_pkg::OQ_DEPTH];
	logic [jsu_pkg::OQ_AW-1:0] wp_q;
	logic [jsu_pkg::OQ_AW-1:0] rp_q;
	logic [CW-1:0]             cnt_q;
	logic                      pop;

	assign pop = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_res = mem_q[rp_q];
	assign room = cnt_q <= CW'(jsu_pkg::OQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[jsu_pkg::OQ_AW'(wp_q + 1'b1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= jsu_pkg::OQ_AW'(wp_q + jsu_pkg::OQ_AW'(push.count));
			rp_q <= jsu_pkg::OQ_AW'(rp_q + jsu_pkg::OQ_AW'(pop));
			cnt_q <= CW'(cnt_q + CW'(push.count) - CW'(pop));
		end
	end

endmodule

FILE: rtl/json_string_unescaper.sv
// top level of the json string unescaper
// Decodes the body of a JSON string, one byte per request after the opening
// quote, into Unicode code points (strict UTF-8 for raw bytes, the standard
// backslash escapes and \uXXXX with surrogate pairing). A closing quote gives a
// done result, a malformed or cut-off string an error result, and the next
// request then starts a new string. Each byte passes an input register, one
// level of decode logic and a four-entry result queue: a byte is taken every
// cycle while the queue has room. Most bytes give at most one result; a held
// high surrogate that is released adds one, and since the queue hands out one
// result per cycle, such extra results and output back-pressure can stall the
// input.
module json_string_unescaper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] end_marker
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [20:0] code_point, [23:21] error_code
	output logic [1:0]  m_tuser,  // [1:0] kind
	output logic        m_tlast
);

	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic             end_s1;
	jsu_pkg::state_t  st_q;
	jsu_pkg::state_t  nx;
	jsu_pkg::push_t   dec_res;
	jsu_pkg::push_t   push;
	logic             room;
	logic             proc;
	logic             take;
	jsu_pkg::result_t head;

	assign proc = vld_s1 && room;
	assign s_tready = !vld_s1 || proc;
	assign take = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
			end_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			st_q <= jsu_pkg::STATE_RESET;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (proc) begin
				vld_s1 <= 1'b0;
			end
			if (proc) begin
				st_q <= nx;
			end
		end
	end

	jsu_decode u_decode (
		.st         (st_q),
		.data_byte  (byte_s1),
		.end_marker (end_s1),
		.nx         (nx),
		.res        (dec_res)
	);

	always_comb begin
		push = dec_res;
		if (!proc) begin
			push.count = 2'd0;
		end
	end

	jsu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (head)
	);

	assign m_tdata = {head.error_code, head.code_point};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

FILE: rtl/jsu_checker.sv
// port checks for the json string unescaper and their binding
module jsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// done and error always close the results of their request
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == jsu_pkg::KIND_DONE || m_tuser == jsu_pkg::KIND_ERR)
		|-> m_tlast)
		else $error("done or error not last");

	// error code only on errors, code point only on decoded characters
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == jsu_pkg::KIND_ERR || m_tdata[23:21] == 3'd0)
			&& (m_tuser == jsu_pkg::KIND_CP || m_tdata[20:0] == 21'd0))
		else $error("stray field bits");

	// code points stay in the unicode range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == jsu_pkg::KIND_CP |-> m_tdata[20:0] <= jsu_pkg::CP_MAX)
		else $error("code point out of range");

	// nothing comes out of a freshly reset block
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result right after reset");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

FILE: tb/tb_top.sv
// self-checking testbench of the json string unescaper with random stream stalls
`timescale 1ns / 100ps

module tb_top;
	import jsu_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int RANDOM_ITEMS = 1850;
	localparam logic [2:0] NO_ERR = 3'd0;

	typedef struct packed {
		logic [7:0] data_b;
		logic       eob;
	} req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	req_t    pend_q[$];
	result_t decoded_q[$];
	result_t step_res[$];

	int src_gap = 0;
	int snk_hold = 0;
	bit src_calm = 1'b0;
	bit snk_calm = 1'b0;
	int errors = 0;
	int unsigned cyc = 0;

	logic [7:0] esc_set[8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	// decoder state
	mode_t       scan_mode = MODE_PLAIN;
	logic [15:0] uhex_acc = '0;
	logic [15:0] high_sur = '0;
	logic [15:0] low_acc = '0;
	logic [20:0] utf_acc = '0;
	logic [1:0]  utf_need = '0;
	logic [7:0]  utf_lead = '0;

	json_string_unescaper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic void add_result(input logic [1:0] k, input logic [20:0] cp,
			input logic [2:0] ec);
		result_t r;
		if (step_res.size() < 2) begin
			r.kind = k;
			r.code_point = cp;
			r.error_code = ec;
			r.last = 1'b0;
			step_res.push_back(r);
		end
	endfunction

	function automatic void clear_scan();
		scan_mode = MODE_PLAIN;
		uhex_acc = '0;
		high_sur = '0;
		low_acc = '0;
		utf_acc = '0;
		utf_need = '0;
		utf_lead = '0;
	endfunction

	function automatic void raise_err(input logic [2:0] ec);
		add_result(KIND_ERR, 21'd0, ec);
		clear_scan();
	endfunction

	function automatic int hex_nibble(input logic [7:0] b);
		logic [7:0] l;
		l = b | 8'h20;
		if (b >= 8'h30 && b <= 8'h39)
			return int'(b - 8'h30);
		if (l >= 8'h61 && l <= 8'h66)
			return int'(l - 8'h61) + 10;
		return -1;
	endfunction

	function automatic void flush_high();
		add_result(KIND_CP, {5'd0, high_sur}, NO_ERR);
		high_sur = '0;
		scan_mode = MODE_PLAIN;
	endfunction

	function automatic void settle_uesc(input logic [15:0] v);
		if (v >= SURR_HI_MIN && v <= SURR_HI_MAX) begin
			high_sur = v;
			scan_mode = MODE_HELD;
		end else begin
			add_result(KIND_CP, {5'd0, v}, NO_ERR);
			scan_mode = MODE_PLAIN;
		end
	endfunction

	function automatic void text_byte(input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = 8'h80;
		hi = 8'hBF;
		if (utf_need != 2'd0) begin
			if (b < CH_SPACE) begin
				raise_err(ERR_CTRL);
				return;
			end
			if (utf_lead == 8'hE0)
				lo = 8'hA0;
			else if (utf_lead == 8'hED)
				hi = 8'h9F;
			else if (utf_lead == 8'hF0)
				lo = 8'h90;
			else if (utf_lead == 8'hF4)
				hi = 8'h8F;
			if (b < lo || b > hi) begin
				raise_err(ERR_UTF8);
				return;
			end
			utf_acc = {utf_acc[14:0], b[5:0]};
			utf_lead = '0;
			utf_need = utf_need - 2'd1;
			if (utf_need == 2'd0) begin
				add_result(KIND_CP, utf_acc, NO_ERR);
				utf_acc = '0;
			end
		end else if (b == CH_QUOTE) begin
			add_result(KIND_DONE, 21'd0, NO_ERR);
			clear_scan();
		end else if (b == CH_BSL) begin
			scan_mode = MODE_ESC;
		end else if (b < CH_SPACE) begin
			raise_err(ERR_CTRL);
		end else if (b < 8'h80) begin
			add_result(KIND_CP, {13'd0, b}, NO_ERR);
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			utf_need = 2'd1;
			utf_acc = {16'd0, b[4:0]};
			utf_lead = b;
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			utf_need = 2'd2;
			utf_acc = {17'd0, b[3:0]};
			utf_lead = b;
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			utf_need = 2'd3;
			utf_acc = {18'd0, b[2:0]};
			utf_lead = b;
		end else begin
			raise_err(ERR_UTF8);
		end
	endfunction

	function automatic void esc_byte(input logic [7:0] b);
		logic [7:0] ch;
		bit ok;
		ok = 1'b1;
		ch = b;
		case (b)
			CH_QUOTE, CH_BSL, CH_SLASH: ch = b;
			CH_B: ch = 8'h08;
			CH_F: ch = 8'h0C;
			CH_N: ch = 8'h0A;
			CH_R: ch = 8'h0D;
			CH_T: ch = 8'h09;
			CH_U: begin
				ok = 1'b0;
				scan_mode = MODE_HEX1;
				uhex_acc = '0;
			end
			default: begin
				ok = 1'b0;
				raise_err(ERR_ESCAPE);
			end
		endcase
		if (ok) begin
			add_result(KIND_CP, {13'd0, ch}, NO_ERR);
			scan_mode = MODE_PLAIN;
		end
	endfunction

	function automatic void close_buffer();
		if (scan_mode >= MODE_HEX1 && scan_mode <= MODE_HEX4) begin
			raise_err(ERR_UNICODE);
		end else if (scan_mode == MODE_HELD || scan_mode == MODE_HELD_ESC) begin
			flush_high();
			raise_err(ERR_UNTERM);
		end else if (scan_mode >= MODE_LOW1 && scan_mode <= MODE_LOW4) begin
			flush_high();
			raise_err(ERR_UNICODE);
		end else begin
			raise_err(ERR_UNTERM);
		end
	endfunction

	function automatic void feed_byte(input logic [7:0] b);
		int d;
		if (scan_mode == MODE_PLAIN) begin
			text_byte(b);
		end else if (scan_mode == MODE_ESC) begin
			esc_byte(b);
		end else if (scan_mode <= MODE_HEX4) begin
			d = hex_nibble(b);
			if (d < 0) begin
				raise_err(ERR_UNICODE);
			end else begin
				uhex_acc = {uhex_acc[11:0], 4'(d)};
				if (scan_mode == MODE_HEX4)
					settle_uesc(uhex_acc);
				else
					scan_mode = mode_t'(scan_mode + 4'd1);
			end
		end else if (scan_mode == MODE_HELD) begin
			if (b == CH_BSL) begin
				scan_mode = MODE_HELD_ESC;
			end else begin
				flush_high();
				text_byte(b);
			end
		end else if (scan_mode == MODE_HELD_ESC) begin
			if (b == CH_U) begin
				scan_mode = MODE_LOW1;
				low_acc = '0;
			end else begin
				flush_high();
				esc_byte(b);
			end
		end else if (scan_mode <= MODE_LOW4) begin
			d = hex_nibble(b);
			if (d < 0) begin
				flush_high();
				raise_err(ERR_UNICODE);
			end else begin
				low_acc = {low_acc[11:0], 4'(d)};
				if (scan_mode != MODE_LOW4) begin
					scan_mode = mode_t'(scan_mode + 4'd1);
				end else if (low_acc >= SURR_LO_MIN && low_acc <= SURR_LO_MAX) begin
					add_result(KIND_CP, SUPP_BASE + (21'(high_sur - SURR_HI_MIN) << 10)
						+ 21'(low_acc - SURR_LO_MIN), NO_ERR);
					high_sur = '0;
					scan_mode = MODE_PLAIN;
				end else begin
					flush_high();
					settle_uesc(low_acc);
				end
			end
		end else begin
			clear_scan();
			text_byte(b);
		end
	endfunction

	function automatic void predict_request(input req_t q);
		step_res.delete();
		if (q.eob)
			close_buffer();
		else
			feed_byte(q.data_b);
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			decoded_q.push_back(step_res[i]);
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int edge_pick(input int lo, input int hi);
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		req_t q;
		q.data_b = b;
		q.eob = 1'b0;
		pend_q.push_back(q);
	endfunction

	function automatic void put_end();
		req_t q;
		q.data_b = 8'($urandom_range(0, 255));
		q.eob = 1'b1;
		pend_q.push_back(q);
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic void put_uesc(input logic [15:0] v);
		put_byte(CH_BSL);
		put_byte(CH_U);
		for (int i = 3; i >= 0; i--)
			put_byte(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic void put_utf8(input logic [20:0] cp);
		if (cp < 21'h800) begin
			put_byte({3'b110, cp[10:6]});
		end else if (cp < 21'h10000) begin
			put_byte({4'b1110, cp[15:12]});
			put_byte({2'b10, cp[11:6]});
		end else begin
			put_byte({5'b11110, cp[20:18]});
			put_byte({2'b10, cp[17:12]});
			put_byte({2'b10, cp[11:6]});
		end
		put_byte({2'b10, cp[5:0]});
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tuser <= 1'b0;
			src_gap <= 0;
		end else begin : drive
			req_t q;
			if (s_tvalid && s_tready) begin
				q.data_b = s_tdata;
				q.eob = s_tuser;
				predict_request(q);
			end
			if ($urandom_range(0, 127) == 0)
				src_calm = ~src_calm;
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					q = pend_q.pop_front();
					s_tdata <= q.data_b;
					s_tuser <= q.eob;
					s_tvalid <= 1'b1;
					src_gap <= pick_gap(src_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_hold <= 0;
		end else begin : watch
			result_t got;
			result_t want;
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.code_point = m_tdata[20:0];
				got.error_code = m_tdata[23:21];
				got.last = m_tlast;
				if (decoded_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: kind %0d cp %h err %0d last %0d",
							got.kind, got.code_point, got.error_code, got.last);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					if (got.kind !== want.kind || got.code_point !== want.code_point
							|| got.error_code !== want.error_code || got.last !== want.last) begin
						if (errors < 10)
							$display("mismatch: expected kind %0d cp %h err %0d last %0d, got kind %0d cp %h err %0d last %0d",
								want.kind, want.code_point, want.error_code, want.last,
								got.kind, got.code_point, got.error_code, got.last);
						errors++;
					end
				end
			end
			if ($urandom_range(0, 127) == 0)
				snk_calm = ~snk_calm;
			if (snk_hold > 0) begin
				snk_hold <= snk_hold - 1;
				m_tready <= 1'b0;
			end else if (!snk_calm && $urandom_range(0, 3) == 0) begin
				snk_hold <= pick_gap(1'b0);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc == LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stim
		int r;
		int n_tok;
		int v;
		int k;
		int start;

		// control byte, bad lead, extremes of printable and of code points
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(CH_SPACE);
		put_byte(8'h7F);
		put_utf8(21'h10FFFF);
		put_byte(CH_QUOTE);
		put_text("\\n\\x");
		put_uesc(16'hD83D);
		put_uesc(16'hDE00);
		put_text("\\u0g");
		put_end();

		start = pend_q.size();
		while (pend_q.size() - start < RANDOM_ITEMS) begin
			n_tok = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 5);
			repeat (n_tok) begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					v = $urandom_range(8'h20, 8'h7F);
					if (v == CH_QUOTE || v == CH_BSL)
						v = 8'h7E;
					put_byte(8'(v));
				end else if (r < 40) begin
					put_utf8(21'(edge_pick(21'h80, 21'h7FF)));
				end else if (r < 50) begin
					v = edge_pick(21'h800, 21'hFFFF);
					if (v >= SURR_HI_MIN && v <= SURR_LO_MAX)
						v = v ^ 16'h2000;
					put_utf8(21'(v));
				end else if (r < 57) begin
					put_utf8(21'(edge_pick(SUPP_BASE, CP_MAX)));
				end else if (r < 67) begin
					put_byte(CH_BSL);
					put_byte(esc_set[$urandom_range(0, 7)]);
				end else if (r < 75) begin
					put_uesc(16'($urandom_range(0, 16'hFFFF)));
				end else if (r < 83) begin
					put_uesc(16'(edge_pick(SURR_HI_MIN, SURR_HI_MAX)));
					put_uesc(16'(edge_pick(SURR_LO_MIN, SURR_LO_MAX)));
				end else if (r < 86) begin
					put_byte(8'($urandom_range(8'hC2, 8'hF4)));
					put_byte(8'($urandom_range(0, 255)));
				end else if (r < 89) begin
					put_byte(CH_BSL);
					put_byte(CH_U);
					k = $urandom_range(0, 3);
					repeat (k)
						put_byte(hex_char(4'($urandom_range(0, 15))));
					put_byte(8'($urandom_range(0, 255)));
				end else if (r < 92) begin
					put_byte(CH_BSL);
					put_byte(8'($urandom_range(0, 255)));
				end else if (r < 96) begin
					put_byte(8'($urandom_range(0, 255)));
				end else if (r < 98) begin
					put_end();
				end else begin
					// broken surrogate pair
					put_uesc(16'(edge_pick(SURR_HI_MIN, SURR_HI_MAX)));
					k = $urandom_range(0, 3);
					if (k == 0) begin
						put_byte(CH_BSL);
						put_byte(esc_set[$urandom_range(0, 7)]);
					end else if (k == 1) begin
						put_uesc(16'($urandom_range(0, 16'hFFFF)));
					end else if (k == 2) begin
						put_byte(CH_BSL);
						put_byte(CH_U);
						repeat ($urandom_range(0, 3))
							put_byte(hex_char(4'($urandom_range(0, 15))));
						put_byte(8'($urandom_range(0, 255)));
					end
				end
			end
			r = $urandom_range(0, 9);
			if (r < 8)
				put_byte(CH_QUOTE);
			else if (r == 8)
				put_end();
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0 && decoded_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
